>>> hdl/cpos2d_pkg.sv
// Shared constants for the 2D closest-point-on-simplex pipeline.
// No dependencies; used by closest_point_on_simplex_2d.
package cpos2d_pkg;

  localparam int CoordBitsDef = 32;

  // The edge weight is an unsigned 0.64 fraction built by the divider.
  localparam int QuotBits = 64;
  // Quotient bits resolved per divider stage.
  localparam int DivStep  = 4;

  // Vertex index codes as they appear on the contributor outputs.
  localparam logic [1:0] IDX_A = 2'd0;
  localparam logic [1:0] IDX_B = 2'd1;
  localparam logic [1:0] IDX_C = 2'd2;

endpackage

>>> hdl/closest_point_on_simplex_2d.sv
// Closest point on a 2D point, segment or triangle, fully pipelined.
// Depends on cpos2d_pkg for the divider geometry and the vertex index codes.
//
// Takes one query in every cycle and never asserts busy_o. Results
// appear on done_o in the order of their start_i transfers. The pipeline
// has four stages of differences, products, sums and region decision,
// a 64-bit restoring divider that resolves four quotient bits per stage
// (16 stages), and three stages that scale the edge vector by the quotient,
// round it and add it back with saturation. There is no way to stall the
// output: a result must be taken in the cycle done_o is high.
module closest_point_on_simplex_2d
  import cpos2d_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   vertex_count_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] closest_x_o,
  output logic signed [COORD_BITS-1:0] closest_y_o,
  output logic [1:0]                   contributor_count_o,
  output logic [1:0]                   contributor_first_o,
  output logic [1:0]                   contributor_second_o,
  output logic [1:0]                   contributor_third_o,
  output logic                         bad_count_o
);

  localparam int DW = COORD_BITS + 1;       // coordinate difference
  localparam int PW = 2 * COORD_BITS + 2;   // product of two differences
  localparam int SW = 2 * COORD_BITS + 3;   // sum of two products
  localparam int RW = SW;                   // divider remainder
  localparam int DivStages = QuotBits / DivStep;
  localparam int Half = QuotBits / 2;
  localparam int MW = DW + Half;            // edge magnitude times half a weight
  localparam int FW = DW + QuotBits + 1;    // full scaled product plus rounding
  localparam int XW = COORD_BITS + 2;       // unsaturated result

  localparam int NXT [3] = '{1, 2, 0};
  // Cross product opposite each edge: AB uses w, BC uses u, CA uses v.
  localparam int OPP [3] = '{3, 1, 2};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0x;
    logic signed [COORD_BITS-1:0] p0y;
    logic [DW-1:0]                emx;
    logic [DW-1:0]                emy;
    logic                         negx;
    logic                         negy;
    logic [1:0]                   cnt;
    logic [1:0]                   k0;
    logic [1:0]                   k1;
    logic [1:0]                   k2;
    logic                         bad;
  } pay_t;

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------- stage 1
  logic signed [COORD_BITS-1:0] px [3];
  logic signed [COORD_BITS-1:0] py [3];
  logic signed [DW-1:0] ex_d [3], ey_d [3], wx_d [3], wy_d [3];
  logic signed [DW-1:0] ux_d [4], uy_d [4], vx_d [4], vy_d [4];

  always_comb begin
    px[0] = vertex_a_x_i;  py[0] = vertex_a_y_i;
    px[1] = vertex_b_x_i;  py[1] = vertex_b_y_i;
    px[2] = vertex_c_x_i;  py[2] = vertex_c_y_i;
    for (int i = 0; i < 3; i++) begin
      ex_d[i] = DW'(px[NXT[i]]) - DW'(px[i]);
      ey_d[i] = DW'(py[NXT[i]]) - DW'(py[i]);
      wx_d[i] = DW'(query_x_i) - DW'(px[i]);
      wy_d[i] = DW'(query_y_i) - DW'(py[i]);
    end
    // Signed area of the triangle.
    ux_d[0] = DW'(px[1]) - DW'(px[0]);
    uy_d[0] = DW'(py[1]) - DW'(py[0]);
    vx_d[0] = DW'(px[2]) - DW'(px[0]);
    vy_d[0] = DW'(py[2]) - DW'(py[0]);
    // Areas of the sub-triangles seen from the query.
    for (int k = 1; k < 4; k++) begin
      ux_d[k] = DW'(px[NXT[k-1]]) - DW'(query_x_i);
      uy_d[k] = DW'(py[NXT[k-1]]) - DW'(query_y_i);
      vx_d[k] = DW'(px[NXT[NXT[k-1]]]) - DW'(query_x_i);
      vy_d[k] = DW'(py[NXT[NXT[k-1]]]) - DW'(query_y_i);
    end
  end

  logic                         s1_valid_q;
  logic [1:0]                   s1_n_q;
  logic signed [COORD_BITS-1:0] s1_px_q [3], s1_py_q [3];
  logic signed [COORD_BITS-1:0] s1_qx_q, s1_qy_q;
  logic signed [DW-1:0] s1_ex_q [3], s1_ey_q [3], s1_wx_q [3], s1_wy_q [3];
  logic signed [DW-1:0] s1_ux_q [4], s1_uy_q [4], s1_vx_q [4], s1_vy_q [4];

  always_ff @(posedge clk_i) begin
    s1_n_q  <= vertex_count_i;
    s1_px_q <= px;
    s1_py_q <= py;
    s1_qx_q <= query_x_i;
    s1_qy_q <= query_y_i;
    s1_ex_q <= ex_d;
    s1_ey_q <= ey_d;
    s1_wx_q <= wx_d;
    s1_wy_q <= wy_d;
    s1_ux_q <= ux_d;
    s1_uy_q <= uy_d;
    s1_vx_q <= vx_d;
    s1_vy_q <= vy_d;
  end

  // ---------------------------------------------------------------- stage 2
  logic                         s2_valid_q;
  logic [1:0]                   s2_n_q;
  logic signed [COORD_BITS-1:0] s2_px_q [3], s2_py_q [3];
  logic signed [COORD_BITS-1:0] s2_qx_q, s2_qy_q;
  logic signed [DW-1:0] s2_ex_q [3], s2_ey_q [3];
  logic signed [PW-1:0] s2_t1_q [3], s2_t2_q [3], s2_d1_q [3], s2_d2_q [3];
  logic signed [PW-1:0] s2_c1_q [4], s2_c2_q [4];

  always_ff @(posedge clk_i) begin
    s2_n_q  <= s1_n_q;
    s2_px_q <= s1_px_q;
    s2_py_q <= s1_py_q;
    s2_qx_q <= s1_qx_q;
    s2_qy_q <= s1_qy_q;
    s2_ex_q <= s1_ex_q;
    s2_ey_q <= s1_ey_q;
    for (int i = 0; i < 3; i++) begin
      s2_t1_q[i] <= PW'(s1_ex_q[i]) * PW'(s1_wx_q[i]);
      s2_t2_q[i] <= PW'(s1_ey_q[i]) * PW'(s1_wy_q[i]);
      s2_d1_q[i] <= PW'(s1_ex_q[i]) * PW'(s1_ex_q[i]);
      s2_d2_q[i] <= PW'(s1_ey_q[i]) * PW'(s1_ey_q[i]);
    end
    for (int k = 0; k < 4; k++) begin
      s2_c1_q[k] <= PW'(s1_ux_q[k]) * PW'(s1_vy_q[k]);
      s2_c2_q[k] <= PW'(s1_uy_q[k]) * PW'(s1_vx_q[k]);
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                         s3_valid_q;
  logic [1:0]                   s3_n_q;
  logic signed [COORD_BITS-1:0] s3_px_q [3], s3_py_q [3];
  logic signed [COORD_BITS-1:0] s3_qx_q, s3_qy_q;
  logic signed [DW-1:0] s3_ex_q [3], s3_ey_q [3];
  logic signed [SW-1:0] s3_t_q [3], s3_d_q [3], s3_cr_q [4];

  always_ff @(posedge clk_i) begin
    s3_n_q  <= s2_n_q;
    s3_px_q <= s2_px_q;
    s3_py_q <= s2_py_q;
    s3_qx_q <= s2_qx_q;
    s3_qy_q <= s2_qy_q;
    s3_ex_q <= s2_ex_q;
    s3_ey_q <= s2_ey_q;
    for (int i = 0; i < 3; i++) begin
      s3_t_q[i] <= SW'(s2_t1_q[i]) + SW'(s2_t2_q[i]);
      s3_d_q[i] <= SW'(s2_d1_q[i]) + SW'(s2_d2_q[i]);
    end
    for (int k = 0; k < 4; k++) begin
      s3_cr_q[k] <= SW'(s2_c1_q[k]) - SW'(s2_c2_q[k]);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Region decision. Vertex and interior results are passed as p0 with a
  // zero edge magnitude, so the scaling stages add nothing to them.
  logic [2:0] vle0, ule0, inner, edge_ok;
  logic [3:0] cz, cn;
  logic       vhit, ehit;
  logic [1:0] vsel, esel;
  pay_t       pay_d;
  logic [RW-1:0] rem_d, den_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vle0[i]  = (s3_d_q[i] == '0) || s3_t_q[i][SW-1] || (s3_t_q[i] == '0);
      ule0[i]  = (s3_d_q[i] != '0) && (s3_t_q[i] >= s3_d_q[i]);
      inner[i] = !vle0[i] && !ule0[i];
    end
    for (int k = 0; k < 4; k++) begin
      cz[k] = (s3_cr_q[k] == '0);
      cn[k] = s3_cr_q[k][SW-1];
    end
    for (int i = 0; i < 3; i++) begin
      edge_ok[i] = inner[i] && (cz[OPP[i]] || cz[0] || (cn[OPP[i]] != cn[0]));
    end

    vhit = 1'b0;
    ehit = 1'b0;
    vsel = IDX_A;
    esel = IDX_A;
    pay_d = '0;
    case (s3_n_q)
      2'd0: pay_d.bad = 1'b1;
      2'd1: vhit = 1'b1;
      2'd2: begin
        if (vle0[0]) begin
          vhit = 1'b1;
        end else if (ule0[0]) begin
          vhit = 1'b1;
          vsel = IDX_B;
        end else begin
          ehit = 1'b1;
        end
      end
      default: begin
        if (ule0[2] && vle0[0]) begin
          vhit = 1'b1;
        end else if (ule0[0] && vle0[1]) begin
          vhit = 1'b1;
          vsel = IDX_B;
        end else if (ule0[1] && vle0[2]) begin
          vhit = 1'b1;
          vsel = IDX_C;
        end else if (edge_ok[0]) begin
          ehit = 1'b1;
        end else if (edge_ok[1]) begin
          ehit = 1'b1;
          esel = IDX_B;
        end else if (edge_ok[2]) begin
          ehit = 1'b1;
          esel = IDX_C;
        end else begin
          pay_d.p0x = s3_qx_q;
          pay_d.p0y = s3_qy_q;
        end
      end
    endcase

    rem_d = RW'(s3_t_q[esel]);
    den_d = RW'(s3_d_q[esel]);
    if (vhit) begin
      pay_d.p0x = s3_px_q[vsel];
      pay_d.p0y = s3_py_q[vsel];
      pay_d.cnt = 2'd1;
      pay_d.k0  = vsel;
    end else if (ehit) begin
      pay_d.p0x  = s3_px_q[esel];
      pay_d.p0y  = s3_py_q[esel];
      pay_d.negx = s3_ex_q[esel][DW-1];
      pay_d.negy = s3_ey_q[esel][DW-1];
      pay_d.emx  = s3_ex_q[esel][DW-1] ? DW'(-s3_ex_q[esel]) : DW'(s3_ex_q[esel]);
      pay_d.emy  = s3_ey_q[esel][DW-1] ? DW'(-s3_ey_q[esel]) : DW'(s3_ey_q[esel]);
      // A degenerate triangle lists all three vertices on an edge hit.
      if (s3_n_q == 2'd3 && cz[0]) begin
        pay_d.cnt = 2'd3;
        pay_d.k0  = IDX_A;
        pay_d.k1  = IDX_B;
        pay_d.k2  = IDX_C;
      end else begin
        pay_d.cnt = 2'd2;
        pay_d.k0  = esel;
        pay_d.k1  = (esel == IDX_C) ? IDX_A : esel + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------- divider
  logic                div_valid_q [DivStages+1];
  logic [RW-1:0]       div_rem_q   [DivStages+1];
  logic [RW-1:0]       div_d_q     [DivStages+1];
  logic [QuotBits-1:0] div_quo_q   [DivStages+1];
  pay_t                div_pay_q   [DivStages+1];

  always_ff @(posedge clk_i) begin
    div_rem_q[0] <= rem_d;
    div_d_q[0]   <= den_d;
    div_quo_q[0] <= '0;
    div_pay_q[0] <= pay_d;
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [RW-1:0]       rem_c;
    logic [QuotBits-1:0] quo_c;

    always_comb begin
      rem_c = div_rem_q[g];
      quo_c = div_quo_q[g];
      for (int s = 0; s < DivStep; s++) begin
        rem_c = {rem_c[RW-2:0], 1'b0};
        if (rem_c >= div_d_q[g]) begin
          rem_c = rem_c - div_d_q[g];
          quo_c = {quo_c[QuotBits-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[QuotBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[g+1] <= 1'b0;
      end else begin
        div_valid_q[g+1] <= div_valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      div_rem_q[g+1] <= rem_c;
      div_d_q[g+1]   <= div_d_q[g];
      div_quo_q[g+1] <= quo_c;
      div_pay_q[g+1] <= div_pay_q[g];
    end
  end

  // ---------------------------------------------------------------- scale
  logic            mul_valid_q;
  logic [MW-1:0]   mxl_q, mxh_q, myl_q, myh_q;
  pay_t            mul_pay_q;

  always_ff @(posedge clk_i) begin
    mxl_q <= MW'(div_pay_q[DivStages].emx) * MW'(div_quo_q[DivStages][Half-1:0]);
    mxh_q <= MW'(div_pay_q[DivStages].emx) * MW'(div_quo_q[DivStages][QuotBits-1:Half]);
    myl_q <= MW'(div_pay_q[DivStages].emy) * MW'(div_quo_q[DivStages][Half-1:0]);
    myh_q <= MW'(div_pay_q[DivStages].emy) * MW'(div_quo_q[DivStages][QuotBits-1:Half]);
    mul_pay_q <= div_pay_q[DivStages];
  end

  // Round half away from zero on the magnitude.
  logic [FW-1:0] fx, fy;
  assign fx = (FW'(mxh_q) << Half) + FW'(mxl_q) + (FW'(1) << (QuotBits - 1));
  assign fy = (FW'(myh_q) << Half) + FW'(myl_q) + (FW'(1) << (QuotBits - 1));

  logic          rnd_valid_q;
  logic [DW-1:0] mx_q, my_q;
  pay_t          rnd_pay_q;

  always_ff @(posedge clk_i) begin
    mx_q      <= fx[QuotBits +: DW];
    my_q      <= fy[QuotBits +: DW];
    rnd_pay_q <= mul_pay_q;
  end

  // ---------------------------------------------------------------- output
  logic signed [XW-1:0] mxs, mys, sx, sy;
  logic signed [COORD_BITS-1:0] cx_d, cy_d;
  localparam logic [COORD_BITS-1:0] SatHi = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SatLo = {1'b1, {(COORD_BITS-1){1'b0}}};

  always_comb begin
    mxs = signed'({1'b0, mx_q});
    mys = signed'({1'b0, my_q});
    sx  = rnd_pay_q.negx ? XW'(rnd_pay_q.p0x) - mxs : XW'(rnd_pay_q.p0x) + mxs;
    sy  = rnd_pay_q.negy ? XW'(rnd_pay_q.p0y) - mys : XW'(rnd_pay_q.p0y) + mys;
    if (sx[XW-1:COORD_BITS-1] == '0 || sx[XW-1:COORD_BITS-1] == '1) begin
      cx_d = sx[COORD_BITS-1:0];
    end else begin
      cx_d = sx[XW-1] ? SatLo : SatHi;
    end
    if (sy[XW-1:COORD_BITS-1] == '0 || sy[XW-1:COORD_BITS-1] == '1) begin
      cy_d = sy[COORD_BITS-1:0];
    end else begin
      cy_d = sy[XW-1] ? SatLo : SatHi;
    end
  end

  logic                         done_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  pay_t                         out_pay_q;

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    out_pay_q <= rnd_pay_q;
  end

  // Valid bits for every stage outside the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      s3_valid_q     <= 1'b0;
      div_valid_q[0] <= 1'b0;
      mul_valid_q    <= 1'b0;
      rnd_valid_q    <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      s1_valid_q     <= start_i && !busy_o;
      s2_valid_q     <= s1_valid_q;
      s3_valid_q     <= s2_valid_q;
      div_valid_q[0] <= s3_valid_q;
      mul_valid_q    <= div_valid_q[DivStages];
      rnd_valid_q    <= mul_valid_q;
      done_q         <= rnd_valid_q;
    end
  end

  assign done_o               = done_q;
  assign closest_x_o          = cx_q;
  assign closest_y_o          = cy_q;
  assign contributor_count_o  = out_pay_q.cnt;
  assign contributor_first_o  = out_pay_q.k0;
  assign contributor_second_o = out_pay_q.k1;
  assign contributor_third_o  = out_pay_q.k2;
  assign bad_count_o          = out_pay_q.bad;

  // ---------------------------------------------------------------- checks
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_count_o |->
      contributor_count_o == 2'd0 && closest_x_o == '0 && closest_y_o == '0)
    else $error("bad count result carries data");

  a_three_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && contributor_count_o == 2'd3 |->
      contributor_first_o == IDX_A && contributor_second_o == IDX_B &&
      contributor_third_o == IDX_C)
    else $error("degenerate edge hit lists wrong vertices");

  a_edge_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid_q[0] && (div_pay_q[0].emx != '0 || div_pay_q[0].emy != '0) |->
      div_d_q[0] != '0)
    else $error("edge interpolation with zero length");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_valid_q |-> mx_q <= rnd_pay_q.emx && my_q <= rnd_pay_q.emy)
    else $error("interpolation step exceeds edge length");

endmodule
